>>> design/iouta_pkg.sv
// Shared types and constants of the IoU track association block.
package iouta_pkg;

   // Field widths fixed by the item format
   localparam int SCORE_BITS = 8;
   localparam int LEN_BITS   = 9;
   localparam int CNT_BITS   = 32;

   // Pair overlap limit is IoU > 1/OVERLAP_DEN
   localparam logic [6:0] OVERLAP_DEN = 7'd100;

   // Start value of the wait-state counter while the IoU pipeline fills; the wait ends when it reaches zero
   localparam logic [1:0] IOU_WAIT_CYCLES = 2'd2;

   // Request codes
   localparam logic CMD_DETECT = 1'b0;
   localparam logic CMD_FRAME  = 1'b1;

   // Register map
   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCORE_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCORE_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_IOU_MIN    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_LENGTH = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_LENGTH = 3'd4;

   // Register reset values
   localparam logic [SCORE_BITS-1:0] RST_SCORE_LOW  = 8'd0;
   localparam logic [SCORE_BITS-1:0] RST_SCORE_HIGH = 8'd128;
   localparam logic [SCORE_BITS-1:0] RST_IOU_MIN    = 8'd128;
   localparam logic [SCORE_BITS-1:0] RST_MIN_LENGTH = 8'd2;
   localparam logic [SCORE_BITS-1:0] RST_MAX_LENGTH = 8'd255;

   // Source of a track table write
   typedef enum logic [1:0] {
      WR_MATCH,   // track extended by its matched detection
      WR_COPY,    // survivor moved down during compaction
      WR_NEW      // detection opens a new track
   } wr_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       det_wr;      // buffer the request detection
      logic       det_rd;      // read detection buffer at det_addr
      logic       det_rd_best; // read detection buffer at best match
      logic       trk_rd;      // read track table
      logic       trk_wr;      // write track table
      wr_sel_type wr_sel;
      logic       ld_a;        // box A <= track read data
      logic       ld_b_trk;    // box B <= track read data
      logic       ld_b_det;    // box B <= detection read data
      logic       best_clr;
      logic       best_take;
      logic       used_set;
      logic       used_clr;
      logic       emit_a;
      logic       emit_b;
      logic       flush;       // send held result as last of frame
      logic       active_set;
      logic       active_inc;
      logic       frame_done;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic ge;          // candidate IoU >= best IoU
      logic ovl;         // pair overlap above limit
      logic keep;        // best IoU >= iou_min
      logic best_valid;
      logic det_ok;      // detection in B qualifies and is unused
      logic a_report;    // track A passes normal report test
      logic b_report;
      logic a_hi;        // track A best score >= score_high
      logic a_over;      // track A longer than max_length
   } stat_type;

endpackage

>>> design/iouta_ctrl.sv
// Frame sequencer: walks the four passes and drives datapath commands.
module iouta_ctrl #(
   parameter int MAX_TRACKS     = 32,
   parameter int MAX_DETECTIONS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   req_cmd,
   output logic                                   busy,
   input  iouta_pkg::stat_type                    stat,
   input  logic [$clog2(MAX_TRACKS+1)-1:0]        active_cnt,
   input  logic [$clog2(MAX_DETECTIONS+1)-1:0]    buffered_cnt,
   output iouta_pkg::cmd_type                     cmd,
   output logic [$clog2(MAX_TRACKS)-1:0]          trk_rd_addr,
   output logic [$clog2(MAX_TRACKS)-1:0]          trk_wr_addr,
   output logic [$clog2(MAX_DETECTIONS)-1:0]      det_addr,
   output logic [$clog2(MAX_TRACKS+1)-1:0]        new_active
);

   localparam int TW = $clog2(MAX_TRACKS+1);
   localparam int TI = $clog2(MAX_TRACKS);
   localparam int DW = $clog2(MAX_DETECTIONS+1);
   localparam int DI = $clog2(MAX_DETECTIONS);

   typedef enum logic [4:0] {
      IDLE,
      WAIT,
      P1_T, P1_TA, P1_D, P1_DB, P1_EV, P1_DEC, P1_MB, P1_MW,
      P2_T, P2_TA, P2_J, P2_JB, P2_EV, P2_EB,
      P3_T, P3_TA, P3_EV,
      CP_T, CP_TA, CP_W,
      P4_D, P4_DB, P4_EV,
      FIN
   } state_type;

   state_type               state_ff, ret_ff;
   logic [1:0]              wait_ff;
   logic [TW-1:0]           t_ff, j_ff, k_ff;
   logic [DW-1:0]           d_ff;
   logic [MAX_TRACKS-1:0]   gone_ff;
   logic                    accept_frame;

   assign busy         = (state_ff != IDLE);
   assign accept_frame = start && (state_ff == IDLE) && (req_cmd == iouta_pkg::CMD_FRAME);
   assign new_active   = k_ff;
   assign det_addr     = d_ff[DI-1:0];

   // Command decode
   always_comb begin
      cmd         = '0;
      cmd.wr_sel  = iouta_pkg::WR_COPY;
      trk_rd_addr = t_ff[TI-1:0];
      trk_wr_addr = t_ff[TI-1:0];
      case (state_ff)
         IDLE: begin
            cmd.det_wr   = start && (req_cmd == iouta_pkg::CMD_DETECT);
            cmd.used_clr = accept_frame;
         end
         P1_T: begin
            cmd.trk_rd   = (t_ff < active_cnt);
            cmd.best_clr = 1'b1;
         end
         P1_TA: cmd.ld_a = 1'b1;
         P1_D: cmd.det_rd = (d_ff < buffered_cnt);
         P1_DB: cmd.ld_b_det = 1'b1;
         P1_EV: cmd.best_take = stat.det_ok && stat.ge;
         P1_DEC: begin
            cmd.det_rd_best = stat.best_valid && stat.keep;
            cmd.emit_a      = !(stat.best_valid && stat.keep) && stat.a_report;
         end
         P1_MB: cmd.ld_b_det = 1'b1;
         P1_MW: begin
            cmd.trk_wr   = 1'b1;
            cmd.wr_sel   = iouta_pkg::WR_MATCH;
            cmd.used_set = 1'b1;
         end
         P2_T: cmd.trk_rd = (t_ff < active_cnt) && !gone_ff[t_ff[TI-1:0]];
         P2_TA: cmd.ld_a = 1'b1;
         P2_J: begin
            trk_rd_addr = j_ff[TI-1:0];
            cmd.trk_rd  = (j_ff < active_cnt) && !gone_ff[j_ff[TI-1:0]];
         end
         P2_JB: cmd.ld_b_trk = 1'b1;
         P2_EV: cmd.emit_a = stat.ovl && stat.a_report;
         P2_EB: cmd.emit_b = stat.b_report;
         P3_T: cmd.trk_rd = (t_ff < active_cnt) && !gone_ff[t_ff[TI-1:0]];
         P3_TA: cmd.ld_a = 1'b1;
         P3_EV: cmd.emit_a = stat.a_over && stat.a_hi;
         CP_T: begin
            cmd.trk_rd     = (t_ff < active_cnt) && !gone_ff[t_ff[TI-1:0]];
            cmd.active_set = !(t_ff < active_cnt);
         end
         CP_TA: cmd.ld_a = 1'b1;
         CP_W: begin
            cmd.trk_wr  = 1'b1;
            trk_wr_addr = k_ff[TI-1:0];
         end
         P4_D: cmd.det_rd = (d_ff < buffered_cnt);
         P4_DB: cmd.ld_b_det = 1'b1;
         P4_EV: begin
            trk_wr_addr    = active_cnt[TI-1:0];
            cmd.trk_wr     = stat.det_ok && (active_cnt < TW'(MAX_TRACKS));
            cmd.wr_sel     = iouta_pkg::WR_NEW;
            cmd.active_inc = cmd.trk_wr;
         end
         FIN: begin
            cmd.flush      = 1'b1;
            cmd.frame_done = 1'b1;
         end
         default: ;
      endcase
   end

   // State, loop counters and finished-track flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ret_ff   <= IDLE;
         wait_ff  <= '0;
         t_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         d_ff     <= '0;
         gone_ff  <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept_frame) begin
                  gone_ff  <= '0;
                  t_ff     <= '0;
                  state_ff <= P1_T;
               end
            end
            WAIT: begin
               if (wait_ff == 2'd0) state_ff <= ret_ff;
               else wait_ff <= wait_ff - 2'd1;
            end
            // pass 1: association
            P1_T: begin
               d_ff <= '0;
               if (t_ff < active_cnt) state_ff <= P1_TA;
               else begin
                  t_ff     <= '0;
                  state_ff <= P2_T;
               end
            end
            P1_TA: state_ff <= P1_D;
            P1_D: state_ff <= (d_ff < buffered_cnt) ? P1_DB : P1_DEC;
            P1_DB: begin
               wait_ff  <= iouta_pkg::IOU_WAIT_CYCLES;
               ret_ff   <= P1_EV;
               state_ff <= WAIT;
            end
            P1_EV: begin
               d_ff     <= d_ff + DW'(1);
               state_ff <= P1_D;
            end
            P1_DEC: begin
               if (stat.best_valid && stat.keep) state_ff <= P1_MB;
               else begin
                  gone_ff[t_ff[TI-1:0]] <= 1'b1;
                  t_ff     <= t_ff + TW'(1);
                  state_ff <= P1_T;
               end
            end
            P1_MB: state_ff <= P1_MW;
            P1_MW: begin
               t_ff     <= t_ff + TW'(1);
               state_ff <= P1_T;
            end
            // pass 2: overlapping pairs
            P2_T: begin
               j_ff <= t_ff + TW'(1);
               if (!(t_ff < active_cnt)) begin
                  t_ff     <= '0;
                  state_ff <= P3_T;
               end else if (gone_ff[t_ff[TI-1:0]]) t_ff <= t_ff + TW'(1);
               else state_ff <= P2_TA;
            end
            P2_TA: state_ff <= P2_J;
            P2_J: begin
               if (!(j_ff < active_cnt)) begin
                  t_ff     <= t_ff + TW'(1);
                  state_ff <= P2_T;
               end else if (gone_ff[j_ff[TI-1:0]]) j_ff <= j_ff + TW'(1);
               else state_ff <= P2_JB;
            end
            P2_JB: begin
               wait_ff  <= iouta_pkg::IOU_WAIT_CYCLES;
               ret_ff   <= P2_EV;
               state_ff <= WAIT;
            end
            P2_EV: begin
               if (stat.ovl) begin
                  // both tracks of the pair finish
                  gone_ff  <= gone_ff | (MAX_TRACKS'(1) << t_ff[TI-1:0])
                                      | (MAX_TRACKS'(1) << j_ff[TI-1:0]);
                  state_ff <= P2_EB;
               end else begin
                  j_ff     <= j_ff + TW'(1);
                  state_ff <= P2_J;
               end
            end
            P2_EB: begin
               t_ff     <= t_ff + TW'(1);
               state_ff <= P2_T;
            end
            // pass 3: over-length
            P3_T: begin
               if (!(t_ff < active_cnt)) begin
                  t_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= CP_T;
               end else if (gone_ff[t_ff[TI-1:0]]) t_ff <= t_ff + TW'(1);
               else state_ff <= P3_TA;
            end
            P3_TA: state_ff <= P3_EV;
            P3_EV: begin
               if (stat.a_over) gone_ff[t_ff[TI-1:0]] <= 1'b1;
               t_ff     <= t_ff + TW'(1);
               state_ff <= P3_T;
            end
            // compaction of survivors
            CP_T: begin
               if (!(t_ff < active_cnt)) begin
                  d_ff     <= '0;
                  state_ff <= P4_D;
               end else if (gone_ff[t_ff[TI-1:0]]) t_ff <= t_ff + TW'(1);
               else state_ff <= CP_TA;
            end
            CP_TA: state_ff <= CP_W;
            CP_W: begin
               k_ff     <= k_ff + TW'(1);
               t_ff     <= t_ff + TW'(1);
               state_ff <= CP_T;
            end
            // pass 4: open new tracks
            P4_D: state_ff <= (d_ff < buffered_cnt) ? P4_DB : FIN;
            P4_DB: state_ff <= P4_EV;
            P4_EV: begin
               d_ff     <= d_ff + DW'(1);
               state_ff <= P4_D;
            end
            FIN: state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

>>> design/iouta_dp.sv
// Datapath: buffers, track table, IoU pipeline, best-match and result registers.
module iouta_dp #(
   parameter int MAX_TRACKS     = 32,
   parameter int MAX_DETECTIONS = 64,
   parameter int COORD_BITS     = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // detection fields
   input  logic [COORD_BITS-1:0]                    req_box_x,
   input  logic [COORD_BITS-1:0]                    req_box_y,
   input  logic [COORD_BITS-1:0]                    req_box_w,
   input  logic [COORD_BITS-1:0]                    req_box_h,
   input  logic [iouta_pkg::SCORE_BITS-1:0]         req_det_score,
   // register writes
   input  logic                                     csr_we,
   input  logic [iouta_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [iouta_pkg::SCORE_BITS-1:0]         csr_wdata,
   // controller link
   input  iouta_pkg::cmd_type                       cmd,
   input  logic [$clog2(MAX_TRACKS)-1:0]            trk_rd_addr,
   input  logic [$clog2(MAX_TRACKS)-1:0]            trk_wr_addr,
   input  logic [$clog2(MAX_DETECTIONS)-1:0]        det_addr,
   input  logic [$clog2(MAX_TRACKS+1)-1:0]          new_active,
   output iouta_pkg::stat_type                      stat,
   output logic [$clog2(MAX_TRACKS+1)-1:0]          active_cnt,
   output logic [$clog2(MAX_DETECTIONS+1)-1:0]      buffered_cnt,
   // results
   output logic                                     rsp_valid,
   output logic [iouta_pkg::CNT_BITS-1:0]           rsp_track_number,
   output logic [iouta_pkg::CNT_BITS-1:0]           rsp_first_frame,
   output logic [iouta_pkg::LEN_BITS-1:0]           rsp_track_length,
   output logic [iouta_pkg::SCORE_BITS-1:0]         rsp_best_score,
   output logic [COORD_BITS-1:0]                    rsp_end_x,
   output logic [COORD_BITS-1:0]                    rsp_end_y,
   output logic [COORD_BITS-1:0]                    rsp_end_w,
   output logic [COORD_BITS-1:0]                    rsp_end_h,
   output logic                                     rsp_last_of_run
);

   localparam int CB = COORD_BITS;
   localparam int TW = $clog2(MAX_TRACKS+1);
   localparam int TI = $clog2(MAX_TRACKS);
   localparam int DW = $clog2(MAX_DETECTIONS+1);
   localparam int DI = $clog2(MAX_DETECTIONS);
   localparam int AW = 2*CB;       // area / intersection
   localparam int UW = 2*CB + 1;   // union
   localparam int PW = AW + UW;    // cross product
   localparam int HW = UW + 8;     // threshold product
   localparam int OW = AW + 7;     // overlap product
   localparam int SB = iouta_pkg::SCORE_BITS;
   localparam int LB = iouta_pkg::LEN_BITS;
   localparam int NB = iouta_pkg::CNT_BITS;

   typedef struct packed {
      logic [CB-1:0] x, y, w, h;
      logic [SB-1:0] score;
      logic [LB-1:0] len;
      logic [NB-1:0] start;
      logic [NB-1:0] ident;
   } trk_rec_type;

   typedef struct packed {
      logic [CB-1:0] x, y, w, h;
      logic [SB-1:0] score;
   } det_rec_type;

   // configuration
   logic [SB-1:0] score_low_ff, score_high_ff, iou_min_ff, min_length_ff, max_length_ff;

   // memories and their read registers
   trk_rec_type trk_mem [MAX_TRACKS];
   det_rec_type det_mem [MAX_DETECTIONS];
   trk_rec_type trk_q_ff;
   det_rec_type det_q_ff;
   logic [DI-1:0] det_q_idx_ff;

   // counters
   logic [TW-1:0] active_ff;
   logic [DW-1:0] buffered_ff;
   logic [NB-1:0] frame_ff, next_ident_ff;
   logic [MAX_DETECTIONS-1:0] used_ff;

   // operand boxes
   trk_rec_type a_ff, b_ff;
   logic [DI-1:0] b_idx_ff;

   // IoU pipeline
   logic [CB-1:0] span_x, span_y;
   logic [AW-1:0] inter_ff, area_a_ff, area_b_ff;
   logic [UW-1:0] uni;
   logic [AW-1:0] ci_ff, ci3_ff;
   logic [UW-1:0] cu_ff, cu3_ff;
   logic [PW-1:0] pn_ff, pb_ff;
   logic [OW-1:0] c100_ff;

   // best match
   logic [AW-1:0] bi_ff;
   logic [UW-1:0] bu_ff;
   logic [HW-1:0] thr_ff;
   logic          best_valid_ff;
   logic [DI-1:0] best_idx_ff;

   // result holding
   trk_rec_type pend_ff, out_ff, wr_data, emit_data;
   logic        pend_valid_ff, out_valid_ff, out_last_ff;
   logic        emit_any;

   logic [DI-1:0] det_rd_addr;

   // overlap of two 1-D extents
   function automatic logic [CB-1:0] span_f(input logic [CB-1:0] lo1, input logic [CB-1:0] l1,
                                            input logic [CB-1:0] lo2, input logic [CB-1:0] l2);
      logic [CB:0] hi1, hi2, lo, hi, diff;
      hi1  = {1'b0, lo1} + {1'b0, l1};
      hi2  = {1'b0, lo2} + {1'b0, l2};
      lo   = (lo1 > lo2) ? {1'b0, lo1} : {1'b0, lo2};
      hi   = (hi1 < hi2) ? hi1 : hi2;
      diff = hi - lo;
      return (hi > lo) ? diff[CB-1:0] : '0;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         score_low_ff  <= iouta_pkg::RST_SCORE_LOW;
         score_high_ff <= iouta_pkg::RST_SCORE_HIGH;
         iou_min_ff    <= iouta_pkg::RST_IOU_MIN;
         min_length_ff <= iouta_pkg::RST_MIN_LENGTH;
         max_length_ff <= iouta_pkg::RST_MAX_LENGTH;
      end else if (csr_we) begin
         case (csr_index)
            iouta_pkg::REG_SCORE_LOW:  score_low_ff  <= csr_wdata;
            iouta_pkg::REG_SCORE_HIGH: score_high_ff <= csr_wdata;
            iouta_pkg::REG_IOU_MIN:    iou_min_ff    <= csr_wdata;
            iouta_pkg::REG_MIN_LENGTH: min_length_ff <= csr_wdata;
            iouta_pkg::REG_MAX_LENGTH: max_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // detection buffer
   assign det_rd_addr = cmd.det_rd_best ? best_idx_ff : det_addr;

   always_ff @(posedge clock) begin
      if (cmd.det_wr && (buffered_ff < DW'(MAX_DETECTIONS)))
         det_mem[buffered_ff[DI-1:0]] <= '{x: req_box_x, y: req_box_y, w: req_box_w,
                                           h: req_box_h, score: req_det_score};
      if (cmd.det_rd || cmd.det_rd_best) begin
         det_q_ff     <= det_mem[det_rd_addr];
         det_q_idx_ff <= det_rd_addr;
      end
   end

   // track table write data
   always_comb begin
      case (cmd.wr_sel)
         iouta_pkg::WR_MATCH: begin
            wr_data       = a_ff;
            wr_data.x     = b_ff.x;
            wr_data.y     = b_ff.y;
            wr_data.w     = b_ff.w;
            wr_data.h     = b_ff.h;
            wr_data.len   = a_ff.len + LB'(1);
            wr_data.score = (b_ff.score > a_ff.score) ? b_ff.score : a_ff.score;
         end
         iouta_pkg::WR_NEW: begin
            wr_data       = b_ff;
            wr_data.len   = LB'(1);
            wr_data.start = frame_ff;
            wr_data.ident = next_ident_ff;
         end
         default: wr_data = a_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.trk_wr) trk_mem[trk_wr_addr] <= wr_data;
      if (cmd.trk_rd) trk_q_ff <= trk_mem[trk_rd_addr];
   end

   // operand boxes
   always_ff @(posedge clock) begin
      if (cmd.ld_a) a_ff <= trk_q_ff;
      if (cmd.ld_b_trk) b_ff <= trk_q_ff;
      if (cmd.ld_b_det) begin
         b_ff     <= '{x: det_q_ff.x, y: det_q_ff.y, w: det_q_ff.w, h: det_q_ff.h,
                       score: det_q_ff.score, default: '0};
         b_idx_ff <= det_q_idx_ff;
      end
   end

   // IoU pipeline: areas, then union, then cross products
   assign span_x = span_f(a_ff.x, a_ff.w, b_ff.x, b_ff.w);
   assign span_y = span_f(a_ff.y, a_ff.h, b_ff.y, b_ff.h);
   assign uni    = {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, inter_ff};

   always_ff @(posedge clock) begin
      inter_ff  <= {{CB{1'b0}}, span_x} * {{CB{1'b0}}, span_y};
      area_a_ff <= {{CB{1'b0}}, a_ff.w} * {{CB{1'b0}}, a_ff.h};
      area_b_ff <= {{CB{1'b0}}, b_ff.w} * {{CB{1'b0}}, b_ff.h};
      // zero union counts as IoU 0/1
      ci_ff     <= (uni == '0) ? '0 : inter_ff;
      cu_ff     <= (uni == '0) ? UW'(1) : uni;
      pn_ff     <= {{UW{1'b0}}, ci_ff} * {{AW{1'b0}}, bu_ff};
      pb_ff     <= {{UW{1'b0}}, bi_ff} * {{AW{1'b0}}, cu_ff};
      c100_ff   <= {7'b0, ci_ff} * {{AW{1'b0}}, iouta_pkg::OVERLAP_DEN};
      ci3_ff    <= ci_ff;
      cu3_ff    <= cu_ff;
      thr_ff    <= {{UW{1'b0}}, iou_min_ff} * {8'b0, bu_ff};
   end

   // best match tracking
   always_ff @(posedge clock) begin
      if (cmd.best_clr) begin
         bi_ff <= '0;
         bu_ff <= UW'(1);
      end else if (cmd.best_take) begin
         bi_ff       <= ci3_ff;
         bu_ff       <= cu3_ff;
         best_idx_ff <= b_idx_ff;
      end
   end

   // counters and used flags
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         buffered_ff   <= '0;
         frame_ff      <= '0;
         next_ident_ff <= '0;
         used_ff       <= '0;
         best_valid_ff <= 1'b0;
      end else begin
         if (cmd.det_wr && (buffered_ff < DW'(MAX_DETECTIONS)))
            buffered_ff <= buffered_ff + DW'(1);
         if (cmd.used_clr) used_ff <= '0;
         else if (cmd.used_set) used_ff[best_idx_ff] <= 1'b1;
         if (cmd.best_clr) best_valid_ff <= 1'b0;
         else if (cmd.best_take) best_valid_ff <= 1'b1;
         if (cmd.active_set) active_ff <= new_active;
         else if (cmd.active_inc) begin
            active_ff     <= active_ff + TW'(1);
            next_ident_ff <= next_ident_ff + NB'(1);
         end
         if (cmd.frame_done) begin
            buffered_ff <= '0;
            frame_ff    <= frame_ff + NB'(1);
         end
      end
   end

   // status
   assign stat.ge         = (pn_ff >= pb_ff);
   assign stat.ovl        = (c100_ff > {6'b0, cu3_ff});
   assign stat.keep       = ({1'b0, bi_ff, 8'b0} >= thr_ff);
   assign stat.best_valid = best_valid_ff;
   assign stat.det_ok     = (b_ff.score >= score_low_ff) && !used_ff[b_idx_ff];
   assign stat.a_hi       = (a_ff.score >= score_high_ff);
   assign stat.a_report   = stat.a_hi && (a_ff.len >= {1'b0, min_length_ff});
   assign stat.b_report   = (b_ff.score >= score_high_ff) && (b_ff.len >= {1'b0, min_length_ff});
   assign stat.a_over     = (a_ff.len > {1'b0, max_length_ff});
   assign active_cnt      = active_ff;
   assign buffered_cnt    = buffered_ff;

   // one result held back so the last of the frame can be flagged
   assign emit_data = cmd.emit_b ? b_ff : a_ff;
   assign emit_any  = cmd.emit_a || cmd.emit_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_last_ff   <= 1'b0;
      end else begin
         out_valid_ff <= (emit_any || cmd.flush) && pend_valid_ff;
         out_last_ff  <= !emit_any && cmd.flush && pend_valid_ff;
         if (emit_any) pend_valid_ff <= 1'b1;
         else if (cmd.flush) pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_any) begin
         out_ff  <= pend_ff;
         pend_ff <= emit_data;
      end else if (cmd.flush) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_track_number = out_ff.ident;
   assign rsp_first_frame  = out_ff.start;
   assign rsp_track_length = out_ff.len;
   assign rsp_best_score   = out_ff.score;
   assign rsp_end_x        = out_ff.x;
   assign rsp_end_y        = out_ff.y;
   assign rsp_end_w        = out_ff.w;
   assign rsp_end_h        = out_ff.h;

endmodule

>>> design/iou_track_association.sv
// Top level of the IoU track association block.
//
// Requests: start with busy low transfers one request. With req_cmd at
// detect the box and score are buffered and busy stays low, so detections
// can stream one per cycle; past the buffer depth they are dropped.
// With req_cmd at end of frame the block goes busy and runs association,
// pair overlap, over-length, compaction and track opening over its tables.
// Each IoU compare goes through one read and a three-stage multiply pipeline
// on single-port track and detection memories.
// Results: each finished track that qualifies is shown for one cycle with
// rsp_valid; rsp_last_of_run marks the frame's last one. The receiver cannot
// stall; results of a frame may still show in the cycle in which busy falls.
// Registers are written through csr_we / csr_index / csr_wdata while idle;
// the user must keep to this, as the block itself does not enforce it.
// Reset empties the track table and buffer, zeroes the frame and track
// counters and loads register defaults; no clearing pass is needed.
module iou_track_association #(
   parameter int MAX_TRACKS     = 32,
   parameter int MAX_DETECTIONS = 64,
   parameter int COORD_BITS     = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_cmd,
   input  logic [COORD_BITS-1:0]                 req_box_x,
   input  logic [COORD_BITS-1:0]                 req_box_y,
   input  logic [COORD_BITS-1:0]                 req_box_w,
   input  logic [COORD_BITS-1:0]                 req_box_h,
   input  logic [iouta_pkg::SCORE_BITS-1:0]      req_det_score,
   output logic                                  rsp_valid,
   output logic [iouta_pkg::CNT_BITS-1:0]        rsp_track_number,
   output logic [iouta_pkg::CNT_BITS-1:0]        rsp_first_frame,
   output logic [iouta_pkg::LEN_BITS-1:0]        rsp_track_length,
   output logic [iouta_pkg::SCORE_BITS-1:0]      rsp_best_score,
   output logic [COORD_BITS-1:0]                 rsp_end_x,
   output logic [COORD_BITS-1:0]                 rsp_end_y,
   output logic [COORD_BITS-1:0]                 rsp_end_w,
   output logic [COORD_BITS-1:0]                 rsp_end_h,
   output logic                                  rsp_last_of_run,
   input  logic                                  csr_we,
   input  logic [iouta_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [iouta_pkg::SCORE_BITS-1:0]      csr_wdata
);

   iouta_pkg::cmd_type                        cmd;
   iouta_pkg::stat_type                       stat;
   logic [$clog2(MAX_TRACKS+1)-1:0]           active_cnt, new_active;
   logic [$clog2(MAX_DETECTIONS+1)-1:0]       buffered_cnt;
   logic [$clog2(MAX_TRACKS)-1:0]             trk_rd_addr, trk_wr_addr;
   logic [$clog2(MAX_DETECTIONS)-1:0]         det_addr;

   // sequencer
   iouta_ctrl #(
      .MAX_TRACKS     (MAX_TRACKS),
      .MAX_DETECTIONS (MAX_DETECTIONS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_cmd      (req_cmd),
      .busy         (busy),
      .stat         (stat),
      .active_cnt   (active_cnt),
      .buffered_cnt (buffered_cnt),
      .cmd          (cmd),
      .trk_rd_addr  (trk_rd_addr),
      .trk_wr_addr  (trk_wr_addr),
      .det_addr     (det_addr),
      .new_active   (new_active)
   );

   // datapath
   iouta_dp #(
      .MAX_TRACKS     (MAX_TRACKS),
      .MAX_DETECTIONS (MAX_DETECTIONS),
      .COORD_BITS     (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_box_x        (req_box_x),
      .req_box_y        (req_box_y),
      .req_box_w        (req_box_w),
      .req_box_h        (req_box_h),
      .req_det_score    (req_det_score),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .trk_rd_addr      (trk_rd_addr),
      .trk_wr_addr      (trk_wr_addr),
      .det_addr         (det_addr),
      .new_active       (new_active),
      .stat             (stat),
      .active_cnt       (active_cnt),
      .buffered_cnt     (buffered_cnt),
      .rsp_valid        (rsp_valid),
      .rsp_track_number (rsp_track_number),
      .rsp_first_frame  (rsp_first_frame),
      .rsp_track_length (rsp_track_length),
      .rsp_best_score   (rsp_best_score),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_end_w        (rsp_end_w),
      .rsp_end_h        (rsp_end_h),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // results only come out of a frame in progress
   a_rsp_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer outside a frame");

   // an end-of-frame transfer starts the sequencer
   a_frame_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == iouta_pkg::CMD_FRAME)) |=> busy)
      else $error("frame request not taken");

   // detections are buffered only while idle
   a_det_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.det_wr |-> !busy)
      else $error("detection buffered during a frame");

endmodule

>>> bench/tb_iou_track_association.sv
// Self-checking testbench for the IoU track association block.
`timescale 1ns / 1ps

module tb_iou_track_association;

   localparam int NTRK = 32;
   localparam int NDET = 64;
   localparam int CB = 12;
   localparam int SB = iouta_pkg::SCORE_BITS;
   localparam int LB = iouta_pkg::LEN_BITS;
   localparam int NB = iouta_pkg::CNT_BITS;
   localparam int IXB = iouta_pkg::CSR_IDX_BITS;
   localparam int SETTLE = 6;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct {
      bit               is_csr;
      logic [IXB-1:0]   idx;
      logic [SB-1:0]    wdata;
      logic             cmd;
      logic [CB-1:0]    x, y, w, h;
      logic [SB-1:0]    score;
      int               idle_pct;
   } op_type;

   typedef struct {
      logic [CB-1:0] x, y, w, h;
   } box_type;

   typedef struct packed {
      logic [NB-1:0] number;
      logic [NB-1:0] first;
      logic [LB-1:0] length;
      logic [SB-1:0] best;
      logic [CB-1:0] x, y, w, h;
      logic          last;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = iouta_pkg::CMD_DETECT;
   logic [CB-1:0] req_box_x = '0, req_box_y = '0, req_box_w = '0, req_box_h = '0;
   logic [SB-1:0] req_det_score = '0;
   logic rsp_valid;
   logic [NB-1:0] rsp_track_number, rsp_first_frame;
   logic [LB-1:0] rsp_track_length;
   logic [SB-1:0] rsp_best_score;
   logic [CB-1:0] rsp_end_x, rsp_end_y, rsp_end_w, rsp_end_h;
   logic rsp_last_of_run;
   logic csr_we = 1'b0;
   logic [IXB-1:0] csr_index = iouta_pkg::REG_SCORE_LOW;
   logic [SB-1:0] csr_wdata = '0;

   iou_track_association uut (.*);

   // Predictor state
   logic [SB-1:0] cfg_score_low = iouta_pkg::RST_SCORE_LOW;
   logic [SB-1:0] cfg_score_high = iouta_pkg::RST_SCORE_HIGH;
   logic [SB-1:0] cfg_iou_min = iouta_pkg::RST_IOU_MIN;
   logic [SB-1:0] cfg_min_len = iouta_pkg::RST_MIN_LENGTH;
   logic [SB-1:0] cfg_max_len = iouta_pkg::RST_MAX_LENGTH;
   box_type trk_box[NTRK];
   logic [SB-1:0] trk_score[NTRK];
   int unsigned trk_len[NTRK];
   logic [NB-1:0] trk_start[NTRK], trk_id[NTRK];
   int n_trk = 0;
   box_type det_box[NDET];
   logic [SB-1:0] det_sc[NDET];
   int n_det = 0;
   logic [NB-1:0] frame_cnt = '0, id_cnt = '0;

   op_type stim_q[$];
   op_type cur;
   report_type frame_reports[$];
   report_type pending_reports[$];
   int errors = 0;
   int quiet = 0;
   int stall_cnt = 0;
   int cur_idle = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned span(int unsigned lo1, len1, lo2, len2);
      int unsigned hi1, hi2, lo, hi;
      hi1 = lo1 + len1;
      hi2 = lo2 + len2;
      lo = (lo1 > lo2) ? lo1 : lo2;
      hi = (hi1 < hi2) ? hi1 : hi2;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   // Overlap ratio as inter/uni; an empty union gives 0/1
   function automatic void box_iou(input box_type a, input box_type b,
                                   output longint unsigned inter, output longint unsigned uni);
      longint unsigned in_a, u;
      in_a = span(a.x, a.w, b.x, b.w) * span(a.y, a.h, b.y, b.h);
      u = longint'(a.w) * a.h + longint'(b.w) * b.h - in_a;
      if (u == 0) begin
         inter = 0;
         uni = 1;
      end else begin
         inter = in_a;
         uni = u;
      end
   endfunction

   function automatic bit normal_report(int t);
      return trk_score[t] >= cfg_score_high && trk_len[t] >= cfg_min_len;
   endfunction

   function automatic void add_report(int t);
      report_type r;
      if (frame_reports.size() >= NTRK) return;
      r.number = trk_id[t];
      r.first = trk_start[t];
      r.length = trk_len[t][LB-1:0];
      r.best = trk_score[t];
      r.x = trk_box[t].x;
      r.y = trk_box[t].y;
      r.w = trk_box[t].w;
      r.h = trk_box[t].h;
      r.last = 1'b0;
      frame_reports.insert(frame_reports.size(), r);
   endfunction

   // End of frame: association, pair overlap, over-length, compaction, opening
   function automatic void predict_frame();
      bit gone[NTRK];
      bit used[NDET];
      int best, k;
      longint unsigned bi, bu, ci, cu;
      frame_reports.delete();
      for (int i = 0; i < NTRK; i++) gone[i] = 0;
      for (int i = 0; i < NDET; i++) used[i] = 0;
      for (int t = 0; t < n_trk; t++) begin
         best = -1;
         bi = 0;
         bu = 1;
         for (int d = 0; d < n_det; d++) begin
            if (used[d] || det_sc[d] < cfg_score_low) continue;
            box_iou(trk_box[t], det_box[d], ci, cu);
            if (ci * bu >= bi * cu) begin
               best = d;
               bi = ci;
               bu = cu;
            end
         end
         if (best >= 0 && bi * 256 >= longint'(cfg_iou_min) * bu) begin
            trk_box[t] = det_box[best];
            trk_len[t]++;
            if (det_sc[best] > trk_score[t]) trk_score[t] = det_sc[best];
            used[best] = 1;
         end else begin
            gone[t] = 1;
            if (normal_report(t)) add_report(t);
         end
      end
      for (int t = 0; t < n_trk; t++) begin
         if (gone[t]) continue;
         for (int j = t + 1; j < n_trk; j++) begin
            if (gone[j]) continue;
            box_iou(trk_box[t], trk_box[j], ci, cu);
            if (ci * iouta_pkg::OVERLAP_DEN > cu) begin
               if (normal_report(t)) add_report(t);
               if (normal_report(j)) add_report(j);
               gone[t] = 1;
               gone[j] = 1;
               break;
            end
         end
      end
      for (int t = 0; t < n_trk; t++) begin
         if (gone[t]) continue;
         if (trk_len[t] > cfg_max_len) begin
            if (trk_score[t] >= cfg_score_high) add_report(t);
            gone[t] = 1;
         end
      end
      k = 0;
      for (int t = 0; t < n_trk; t++) begin
         if (gone[t]) continue;
         trk_box[k] = trk_box[t];
         trk_score[k] = trk_score[t];
         trk_len[k] = trk_len[t];
         trk_start[k] = trk_start[t];
         trk_id[k] = trk_id[t];
         k++;
      end
      n_trk = k;
      for (int d = 0; d < n_det; d++) begin
         if (used[d] || det_sc[d] < cfg_score_low || n_trk >= NTRK) continue;
         trk_box[n_trk] = det_box[d];
         trk_score[n_trk] = det_sc[d];
         trk_len[n_trk] = 1;
         trk_start[n_trk] = frame_cnt;
         trk_id[n_trk] = id_cnt;
         id_cnt++;
         n_trk++;
      end
      n_det = 0;
      frame_cnt++;
      if (frame_reports.size() > 0) frame_reports[frame_reports.size()-1].last = 1'b1;
      foreach (frame_reports[i]) pending_reports.insert(pending_reports.size(), frame_reports[i]);
   endfunction

   function automatic void predict_request(op_type op);
      if (op.cmd == iouta_pkg::CMD_FRAME) begin
         predict_frame();
      end else if (n_det < NDET) begin
         det_box[n_det] = '{op.x, op.y, op.w, op.h};
         det_sc[n_det] = op.score;
         n_det++;
      end
   endfunction

   function automatic void apply_csr(logic [IXB-1:0] idx, logic [SB-1:0] v);
      case (idx)
         iouta_pkg::REG_SCORE_LOW:  cfg_score_low = v;
         iouta_pkg::REG_SCORE_HIGH: cfg_score_high = v;
         iouta_pkg::REG_IOU_MIN:    cfg_iou_min = v;
         iouta_pkg::REG_MIN_LENGTH: cfg_min_len = v;
         iouta_pkg::REG_MAX_LENGTH: cfg_max_len = v;
         default: ;
      endcase
   endfunction

   // Driver: request transfers and register writes
   always @(posedge clock) begin
      bit fire, nxt_start, nxt_we;
      op_type op;
      fire = start && !busy;
      nxt_start = start && busy;
      nxt_we = 1'b0;
      if (reset) begin
         quiet <= 0;
      end else begin
         if (fire) predict_request(cur);
         quiet <= (!busy && !start) ? quiet + 1 : 0;
         if (!nxt_start && stim_q.size() > 0) begin
            op = stim_q[0];
            if (op.is_csr) begin
               // registers change only with the block idle and drained
               if (!busy && !start && pending_reports.size() == 0 && quiet >= SETTLE) begin
                  void'(stim_q.pop_front());
                  apply_csr(op.idx, op.wdata);
                  nxt_we = 1'b1;
                  csr_index <= op.idx;
                  csr_wdata <= op.wdata;
               end
            end else if ($urandom_range(99) >= op.idle_pct) begin
               void'(stim_q.pop_front());
               cur <= op;
               nxt_start = 1'b1;
               req_cmd <= op.cmd;
               req_box_x <= op.x;
               req_box_y <= op.y;
               req_box_w <= op.w;
               req_box_h <= op.h;
               req_det_score <= op.score;
            end
         end
      end
      start <= reset ? 1'b0 : nxt_start;
      csr_we <= nxt_we;
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      report_type act, exp_r;
      if (!reset && rsp_valid) begin
         act = '{rsp_track_number, rsp_first_frame, rsp_track_length, rsp_best_score,
                 rsp_end_x, rsp_end_y, rsp_end_w, rsp_end_h, rsp_last_of_run};
         if (pending_reports.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: %p", act);
         end else begin
            exp_r = pending_reports.pop_front();
            if (act !== exp_r) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, act);
            end
         end
      end
   end

   // Watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   function automatic void stim_append(op_type op);
      stim_q.insert(stim_q.size(), op);
   endfunction

   task automatic push_csr(logic [IXB-1:0] idx, int v);
      op_type op;
      op = '{default: '0};
      op.is_csr = 1'b1;
      op.idx = idx;
      op.wdata = v[SB-1:0];
      stim_append(op);
   endtask

   task automatic push_cfg(int lo, int hi, int iou, int mn, int mx);
      push_csr(iouta_pkg::REG_SCORE_LOW, lo);
      push_csr(iouta_pkg::REG_SCORE_HIGH, hi);
      push_csr(iouta_pkg::REG_IOU_MIN, iou);
      push_csr(iouta_pkg::REG_MIN_LENGTH, mn);
      push_csr(iouta_pkg::REG_MAX_LENGTH, mx);
   endtask

   task automatic push_det(int x, int y, int w, int h, int s);
      op_type op;
      op = '{default: '0};
      op.cmd = iouta_pkg::CMD_DETECT;
      op.x = x[CB-1:0];
      op.y = y[CB-1:0];
      op.w = w[CB-1:0];
      op.h = h[CB-1:0];
      op.score = s[SB-1:0];
      op.idle_pct = cur_idle;
      stim_append(op);
   endtask

   task automatic push_frame();
      op_type op;
      op = '{default: '0};
      op.cmd = iouta_pkg::CMD_FRAME;
      op.idle_pct = cur_idle;
      stim_append(op);
   endtask

   // Objects drift in separate columns so tracks persist; some drop out,
   // some respawn, and stray boxes over the full range add noise
   task automatic run_scene(int frames);
      int ox[6], oy[6], ow[6], oh[6];
      for (int i = 0; i < 6; i++) begin
         ox[i] = i * 640 + int'($urandom_range(3, 300));
         oy[i] = int'($urandom_range(3, 3800));
         ow[i] = int'($urandom_range(8, 250));
         oh[i] = int'($urandom_range(8, 250));
      end
      for (int f = 0; f < frames; f++) begin
         for (int i = 0; i < 6; i++) begin
            if ($urandom_range(9) == 0) begin
               ox[i] = i * 640 + int'($urandom_range(3, 300));
               oy[i] = int'($urandom_range(3, 3800));
            end
            ox[i] = ox[i] + int'($urandom_range(6)) - 3;
            oy[i] = oy[i] + int'($urandom_range(6)) - 3;
            if (ox[i] < 0) ox[i] = 0;
            if (oy[i] < 0) oy[i] = 0;
            if ($urandom_range(9) < 8)
               push_det(ox[i], oy[i], ow[i], oh[i], $urandom_range(255));
         end
         if ($urandom_range(3) == 0)
            push_det($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(255));
         push_frame();
      end
   endtask

   initial begin
      // first phase: sender idles now and then
      cur_idle = 19;
      push_cfg(0, 100, 128, 2, 255);
      push_det(4095, 4095, 4095, 4095, 255);
      push_det(0, 0, 0, 0, 0);
      push_det(100, 100, 50, 50, 200);
      push_frame();
      push_det(0, 0, 0, 0, 255);
      push_det(102, 101, 50, 50, 255);
      push_det(4095, 4095, 4095, 4095, 0);
      push_frame();
      push_det(104, 100, 52, 50, 10);
      push_frame();
      push_frame();
      run_scene(8);

      // second phase: sender idles most of the time
      cur_idle = 78;
      push_cfg(255, 0, 0, 0, 1);
      run_scene(3);
      push_cfg(0, 0, 0, 0, 1);
      run_scene(3);
      // more detections than the track table holds, then all tracks finish
      push_cfg(0, 0, 128, 0, 255);
      for (int i = 0; i < 40; i++) push_det((i % 8) * 500, (i / 8) * 500, 100, 100, 200);
      push_frame();
      push_frame();
      // more detections than the buffer holds
      for (int i = 0; i < 66; i++)
         push_det($urandom_range(4095), $urandom_range(4095), $urandom_range(200),
                  $urandom_range(200), $urandom_range(255));
      push_frame();
      push_frame();

      // third phase: no idling
      cur_idle = 0;
      push_cfg(255, 255, 255, 255, 255);
      run_scene(3);
      push_cfg(40, 90, 100, 3, 4);
      run_scene(10);
      push_frame();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (stim_q.size() > 0 || start || busy || pending_reports.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/iouta_pkg.sv
design/iouta_ctrl.sv
design/iouta_dp.sv
design/iou_track_association.sv
bench/tb_iou_track_association.sv
